[src/ble_sde_pkg.sv]
// ble_sde_pkg: shared types for the service data extractor
// holds the input word and result word structs, no dependencies
package ble_sde_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W  = 10;
  localparam int UUID_W = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
    logic [POS_W-1:0]  record_size;
  } item_t;

  typedef struct packed {
    logic              entry_found;
    logic [UUID_W-1:0] service_uuid;
    logic [POS_W-1:0]  payload_offset;
    logic [BYTE_W-1:0] payload_length;
    logic              done_res;
  } result_t;

  typedef struct packed {
    logic step;
    logic res_valid;
  } ctrl_t;

endpackage

[src/ble_sde_in_reg.sv]
// ble_sde_in_reg: input register stage of the extractor
// depends on ble_sde_pkg for item_t
module ble_sde_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ble_sde_pkg::item_t  in_item,
  input  logic                step,
  output logic                s1_valid,
  output ble_sde_pkg::item_t  s1_item
);
  import ble_sde_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

[src/ble_sde_parser.sv]
// ble_sde_parser: length-type-value walker state and per-byte step logic
// depends on ble_sde_pkg for item_t and result_t
module ble_sde_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  ble_sde_pkg::item_t        item,
  input  logic [7:0]                svc_type,
  output logic                      res_valid,
  output ble_sde_pkg::result_t      res
);
  import ble_sde_pkg::*;

  localparam logic [2:0] PH_LENGTH  = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_UUID_LO = 3'd2;
  localparam logic [2:0] PH_UUID_HI = 3'd3;
  localparam logic [2:0] PH_SKIP    = 3'd4;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  size_r, size_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] left_r, left_nxt;
  logic [BYTE_W-1:0] lo_r, lo_nxt;
  logic              halt_r, halt_nxt;

  logic [POS_W-1:0]  pos_c, size_c, remaining, pos_inc;
  logic [BYTE_W-1:0] len_c, left_c, left_dec, lo_c, b;
  logic [2:0]        phase_c;
  logic              halt_c;

  always_comb begin
    b       = item.data_byte;
    size_c  = item.first_byte ? item.record_size : size_r;
    pos_c   = item.first_byte ? '0 : pos_r;
    phase_c = item.first_byte ? PH_LENGTH : phase_r;
    len_c   = item.first_byte ? '0 : len_r;
    left_c  = item.first_byte ? '0 : left_r;
    lo_c    = item.first_byte ? '0 : lo_r;
    halt_c  = item.first_byte ? (item.record_size == '0) : halt_r;

    remaining = size_c - pos_c;
    pos_inc   = pos_c + 1'b1;
    left_dec  = (left_c != '0) ? left_c - 1'b1 : left_c;

    size_nxt  = size_c;
    pos_nxt   = pos_c;
    phase_nxt = phase_c;
    len_nxt   = len_c;
    left_nxt  = left_c;
    lo_nxt    = lo_c;
    halt_nxt  = halt_c;
    res_valid = 1'b0;
    res       = '0;

    if (item.first_byte && item.record_size == '0) begin
      res_valid    = 1'b1;
      res.done_res = 1'b1;
    end else if (!halt_c) begin
      if (phase_c == PH_LENGTH) begin
        if (b == '0 || {{(POS_W-BYTE_W){1'b0}}, b} >= remaining) begin
          halt_nxt     = 1'b1;
          res_valid    = 1'b1;
          res.done_res = 1'b1;
        end else begin
          len_nxt   = b;
          left_nxt  = b;
          phase_nxt = PH_TYPE;
          pos_nxt   = pos_inc;
        end
      end else begin
        case (phase_c)
          PH_TYPE: begin
            phase_nxt = (b == svc_type && len_c >= 8'd3) ? PH_UUID_LO : PH_SKIP;
          end
          PH_UUID_LO: begin
            lo_nxt    = b;
            phase_nxt = PH_UUID_HI;
          end
          PH_UUID_HI: begin
            res.entry_found    = 1'b1;
            res.service_uuid   = {b, lo_c};
            res.payload_offset = pos_inc;
            res.payload_length = len_c - 8'd3;
            phase_nxt          = PH_SKIP;
          end
          default: begin
            phase_nxt = PH_SKIP;
          end
        endcase
        left_nxt = left_dec;
        pos_nxt  = pos_inc;
        if (left_dec == '0) begin
          phase_nxt = PH_LENGTH;
          if (pos_inc >= size_c) begin
            halt_nxt     = 1'b1;
            res.done_res = 1'b1;
          end
        end
        res_valid = res.entry_found || res.done_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      size_r  <= '0;
      phase_r <= PH_LENGTH;
      len_r   <= '0;
      left_r  <= '0;
      lo_r    <= '0;
      halt_r  <= 1'b1;
    end else if (step) begin
      pos_r   <= pos_nxt;
      size_r  <= size_nxt;
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      left_r  <= left_nxt;
      lo_r    <= lo_nxt;
      halt_r  <= halt_nxt;
    end
  end

endmodule

[src/ble_sde_out_reg.sv]
// ble_sde_out_reg: result register toward the output channel
// depends on ble_sde_pkg for result_t and ctrl_t
module ble_sde_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ble_sde_pkg::ctrl_t    ctrl,
  input  ble_sde_pkg::result_t  res,
  input  logic                  out_ready,
  output logic                  out_valid,
  output ble_sde_pkg::result_t  out_res
);
  import ble_sde_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  logic    load;

  assign load = ctrl.step && ctrl.res_valid;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[src/ble_service_data_extractor.sv]
// ble_service_data_extractor: top level of the service data extractor
// depends on ble_sde_pkg, ble_sde_in_reg, ble_sde_parser, ble_sde_out_reg
//
// Input channel in_*: one record byte per word; in_first_byte marks the
// first byte of a record and carries in_record_size. Output channel out_*:
// zero or one result word per input word, giving a service data entry
// (UUID, payload offset, payload length) and/or the done flag that ends
// the record. Bytes after done are dropped until the next first byte.
// cfg_wr_en/cfg_wr_data write the service data type code (reset 0x16).
// Throughput: one word per cycle, sustained, with both sides ready.
// The input register holds the accepted byte, then the parser step loads
// the result register once the result register is empty or being read.
// The parser step is a single compare-and-count pass per byte.
// Reset (rst_n low, synchronous) empties both registers and leaves the
// parser halted until a first byte arrives.
// When the receiver stalls, the result word holds; at most one more input word is
// taken into the input register and then in_ready drops until the result
// register frees.
module ble_service_data_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [9:0]  in_record_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_entry_found,
  output logic [15:0] out_service_uuid,
  output logic [9:0]  out_payload_offset,
  output logic [7:0]  out_payload_length,
  output logic        out_done_res,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import ble_sde_pkg::*;

  logic [7:0] svc_type_r;
  item_t      in_item;
  item_t      s1_item;
  logic       s1_valid;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  ctrl_t      ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svc_type_r <= 8'h16;
    end else if (cfg_wr_en) begin
      svc_type_r <= cfg_wr_data;
    end
  end

  assign in_item.data_byte   = in_data_byte;
  assign in_item.first_byte  = in_first_byte;
  assign in_item.record_size = in_record_size;

  assign step = s1_valid && (!out_valid || out_ready);

  ble_sde_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .step     (step),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  ble_sde_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item),
    .svc_type  (svc_type_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign ctrl.step      = step;
  assign ctrl.res_valid = res_valid;

  ble_sde_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_entry_found    = out_res.entry_found;
  assign out_service_uuid   = out_res.service_uuid;
  assign out_payload_offset = out_res.payload_offset;
  assign out_payload_length = out_res.payload_length;
  assign out_done_res       = out_res.done_res;

endmodule

[src/ble_sde_checker.sv]
// ble_sde_checker: port-level checks on the extractor's result channel
// bound to ble_service_data_extractor, no package dependency
module ble_sde_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_entry_found,
  input logic [15:0] out_service_uuid,
  input logic [9:0]  out_payload_offset,
  input logic [7:0]  out_payload_length,
  input logic        out_done_res
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_service_uuid)
      && $stable(out_payload_offset) && $stable(out_done_res))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_plain_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_found |-> out_done_res
      && out_service_uuid == 16'd0 && out_payload_offset == 10'd0
      && out_payload_length == 8'd0)
    else $error("result word without entry is not a clean done");

  a_entry_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_found |-> out_payload_offset >= 10'd3)
    else $error("entry payload offset below header size");

endmodule

bind ble_service_data_extractor ble_sde_checker u_ble_sde_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_entry_found    (out_entry_found),
  .out_service_uuid   (out_service_uuid),
  .out_payload_offset (out_payload_offset),
  .out_payload_length (out_payload_length),
  .out_done_res       (out_done_res)
);

[dv/tb_top.sv]
// tb_top: self-checking testbench for ble_service_data_extractor
// depends on ble_sde_pkg and the block; drives directed and random advertising records,
// predicts or tables every result word in the testbench and checks the out_* stream in order
module tb_top;
  import ble_sde_pkg::*;

  localparam int MAX_REC_BYTES   = 1024;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int HOLD_CYCLES     = 120;
  localparam int SETTLE_CYCLES   = 6;
  localparam bit TYPED           = 1'b1;
  localparam bit PREDICTED       = 1'b0;

  typedef enum logic [2:0] {
    ST_LENGTH,
    ST_TYPE,
    ST_UUID_LO,
    ST_UUID_HI,
    ST_PAYLOAD
  } parse_st_t;

  typedef struct {
    item_t   w;
    bit      typed;
    bit      has_res;
    result_t res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic [9:0]  in_record_size;
  logic        out_valid;
  logic        out_ready;
  logic        out_entry_found;
  logic [15:0] out_service_uuid;
  logic [9:0]  out_payload_offset;
  logic [7:0]  out_payload_length;
  logic        out_done_res;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;

  ble_service_data_extractor u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_first_byte      (in_first_byte),
    .in_record_size     (in_record_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_entry_found    (out_entry_found),
    .out_service_uuid   (out_service_uuid),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_done_res       (out_done_res),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  // parser copy
  logic [7:0] svc_type;
  int         rec_pos;
  int         rec_size;
  parse_st_t  parse_st;
  logic [7:0] struct_len;
  logic [7:0] struct_left;
  logic [7:0] uuid_lo;
  bit         halted;

  result_t expected_results[$];
  row_t    directed_rows[$];
  int      fail_count;
  int      record_items;
  bit      hold_req;
  bit      in_calm;
  bit      out_calm;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic item_t mk_word(input logic [7:0] b, input logic first,
                                    input logic [9:0] size);
    item_t w;
    w.data_byte   = b;
    w.first_byte  = first;
    w.record_size = size;
    return w;
  endfunction

  function automatic result_t mk_res(input logic entry, input logic [15:0] uuid,
                                     input logic [9:0] off, input logic [7:0] len,
                                     input logic done);
    result_t r;
    r.entry_found    = entry;
    r.service_uuid   = uuid;
    r.payload_offset = off;
    r.payload_length = len;
    r.done_res       = done;
    return r;
  endfunction

  function automatic void add_row(input item_t w, input bit typed, input bit has_res,
                                  input result_t res);
    row_t row;
    row.w       = w;
    row.typed   = typed;
    row.has_res = has_res;
    row.res     = res;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // one byte through the parser; returns 1 when a result word is due
  function automatic bit parse_byte(input item_t w, output result_t r);
    int rem;
    bit done;
    r = '0;
    done = 1'b0;
    if (w.first_byte) begin
      rec_size = int'(w.record_size);
      if (rec_size > MAX_REC_BYTES) rec_size = MAX_REC_BYTES;
      rec_pos     = 0;
      parse_st    = ST_LENGTH;
      struct_len  = '0;
      struct_left = '0;
      uuid_lo     = '0;
      halted      = 1'b0;
      if (rec_size == 0) begin
        halted     = 1'b1;
        r.done_res = 1'b1;
        return 1'b1;
      end
    end
    if (halted) return 1'b0;
    if (parse_st == ST_LENGTH) begin
      rem = rec_size - rec_pos;
      if (w.data_byte == 8'd0 || int'(w.data_byte) >= rem) begin
        halted     = 1'b1;
        r.done_res = 1'b1;
        return 1'b1;
      end
      struct_len  = w.data_byte;
      struct_left = w.data_byte;
      parse_st    = ST_TYPE;
      rec_pos++;
      return 1'b0;
    end
    case (parse_st)
      ST_TYPE: begin
        if (w.data_byte == svc_type && struct_len >= 8'd3) parse_st = ST_UUID_LO;
        else parse_st = ST_PAYLOAD;
      end
      ST_UUID_LO: begin
        uuid_lo  = w.data_byte;
        parse_st = ST_UUID_HI;
      end
      ST_UUID_HI: begin
        r.entry_found    = 1'b1;
        r.service_uuid   = {w.data_byte, uuid_lo};
        r.payload_offset = POS_W'(rec_pos + 1);
        r.payload_length = struct_len - 8'd3;
        parse_st         = ST_PAYLOAD;
      end
      default: begin
        parse_st = ST_PAYLOAD;
      end
    endcase
    if (struct_left > 0) struct_left--;
    rec_pos++;
    if (struct_left == 0) begin
      parse_st = ST_LENGTH;
      if (rec_pos >= rec_size) begin
        halted = 1'b1;
        done   = 1'b1;
      end
    end
    r.done_res = done;
    return r.entry_found || done;
  endfunction

  task automatic send_word(input item_t w, output bit has_res, output result_t r);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= w.data_byte;
    in_first_byte  <= w.first_byte;
    in_record_size <= w.record_size;
    do @(posedge clk); while (!in_ready);
    has_res = parse_byte(w, r);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_service_type(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    svc_type = v;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_record();
    item_t   words[$];
    int      size;
    int      pos;
    int      rem;
    int      len;
    int      maxl;
    int      cut;
    int      noise;
    bit      big;
    bit      has_res;
    result_t r;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3))
        words = {words, mk_word(8'($urandom), 1'b0, 10'($urandom))};
    noise = words.size();
    big = ($urandom_range(0, 11) == 0);
    size = big ? $urandom_range(256, 1023) : $urandom_range(1, 40);
    if ($urandom_range(0, 24) == 0) size = 0;
    if (size == 0) words = {words, mk_word(8'($urandom), 1'b1, 10'd0)};
    pos = 0;
    while (pos < size) begin
      rem = size - pos;
      if (big && pos > 48) begin
        len = 0;
      end else if ($urandom_range(0, 19) == 0) begin
        // broken structure: zero length or one that overruns the record
        len = ($urandom_range(0, 1) || rem > 255) ? 0 : $urandom_range(rem, 255);
      end else if (rem == 1) begin
        len = $urandom_range(0, 255);
      end else begin
        maxl = (rem - 1 > 255) ? 255 : rem - 1;
        if (big && $urandom_range(0, 3) == 0) begin
          len = maxl;
        end else begin
          if (maxl > 12 && $urandom_range(0, 3) != 0) maxl = 12;
          len = $urandom_range(1, maxl);
        end
      end
      words = {words, mk_word(8'(len), (pos == 0),
                              (pos == 0) ? 10'(size) : 10'($urandom))};
      if (len == 0 || len >= rem) break;
      words = {words, mk_word($urandom_range(0, 1) ? svc_type : 8'($urandom), 1'b0,
                              10'($urandom))};
      repeat (len - 1) words = {words, mk_word(8'($urandom), 1'b0, 10'($urandom))};
      pos += len + 1;
    end
    // cut short so the next first byte lands mid-record
    if (words.size() > noise + 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(noise + 1, words.size() - 1);
      while (words.size() > cut) void'(words.pop_back());
    end
    in_calm = ($urandom_range(0, 3) == 0);
    foreach (words[i]) begin
      send_word(words[i], has_res, r);
      if (has_res) expected_results = {expected_results, r};
    end
    record_items += words.size() - noise;
  endtask

  // result side
  initial begin
    int      gap;
    result_t want;
    result_t got;
    out_ready = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = draw_gap(out_calm);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got = mk_res(out_entry_found, out_service_uuid, out_payload_offset,
                   out_payload_length, out_done_res);
      if (expected_results.size() == 0) begin
        $error("unexpected result word: %p", got);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.entry_found !== want.entry_found) begin
          $error("entry_found: expected %0d, got %0d", want.entry_found, got.entry_found);
          fail_count++;
        end
        if (got.service_uuid !== want.service_uuid) begin
          $error("service_uuid: expected %h, got %h", want.service_uuid, got.service_uuid);
          fail_count++;
        end
        if (got.payload_offset !== want.payload_offset) begin
          $error("payload_offset: expected %0d, got %0d", want.payload_offset,
                 got.payload_offset);
          fail_count++;
        end
        if (got.payload_length !== want.payload_length) begin
          $error("payload_length: expected %0d, got %0d", want.payload_length,
                 got.payload_length);
          fail_count++;
        end
        if (got.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
          fail_count++;
        end
      end
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
    end
  end

  // stimulus
  initial begin
    int      plan[5];
    bit      has_res;
    bit      paused;
    result_t r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = '0;
    in_first_byte  = 1'b0;
    in_record_size = '0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    fail_count     = 0;
    record_items   = 0;
    hold_req       = 1'b0;
    in_calm        = 1'b0;
    out_calm       = 1'b0;
    paused         = 1'b0;
    svc_type       = 8'h16;
    rec_pos        = 0;
    rec_size       = 0;
    parse_st       = ST_LENGTH;
    struct_len     = '0;
    struct_left    = '0;
    uuid_lo        = '0;
    halted         = 1'b1;

    // byte before any record, then an empty record
    add_row(mk_word(8'hAA, 1'b0, 10'd0), TYPED, 1'b0, '0);
    add_row(mk_word(8'hFF, 1'b1, 10'd0), TYPED, 1'b1,
            mk_res(1'b0, 16'd0, 10'd0, 8'd0, 1'b1));
    // one service data structure filling the record
    add_row(mk_word(8'h05, 1'b1, 10'd6), TYPED, 1'b0, '0);
    add_row(mk_word(8'h16, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h34, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h12, 1'b0, 10'd0), TYPED, 1'b1,
            mk_res(1'b1, 16'h1234, 10'd4, 8'd2, 1'b0));
    add_row(mk_word(8'hAB, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'hCD, 1'b0, 10'd0), TYPED, 1'b1,
            mk_res(1'b0, 16'd0, 10'd0, 8'd0, 1'b1));
    // uuid high byte is the last byte of the record
    add_row(mk_word(8'h03, 1'b1, 10'd4), TYPED, 1'b0, '0);
    add_row(mk_word(8'h16, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'hFF, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'hFF, 1'b0, 10'h3FF), TYPED, 1'b1,
            mk_res(1'b1, 16'hFFFF, 10'd4, 8'd0, 1'b1));
    // zero length halts, later bytes dropped
    add_row(mk_word(8'h00, 1'b1, 10'd10), TYPED, 1'b1,
            mk_res(1'b0, 16'd0, 10'd0, 8'd0, 1'b1));
    add_row(mk_word(8'h55, 1'b0, 10'h3FF), TYPED, 1'b0, '0);
    // length runs past the record end
    add_row(mk_word(8'h03, 1'b1, 10'd3), TYPED, 1'b1,
            mk_res(1'b0, 16'd0, 10'd0, 8'd0, 1'b1));
    // service type but too short for a uuid
    add_row(mk_word(8'h02, 1'b1, 10'd3), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h16, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h00, 1'b0, 10'd0), TYPED, 1'b1,
            mk_res(1'b0, 16'd0, 10'd0, 8'd0, 1'b1));
    // largest record, restarted mid-structure
    add_row(mk_word(8'hFF, 1'b1, 10'h3FF), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h16, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h00, 1'b0, 10'd0), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h01, 1'b1, 10'd2), PREDICTED, 1'b0, '0);
    add_row(mk_word(8'h00, 1'b0, 10'd0), TYPED, 1'b1,
            mk_res(1'b0, 16'd0, 10'd0, 8'd0, 1'b1));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_service_type(8'h16);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].w, has_res, r);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_res)
          expected_results = {expected_results, directed_rows[i].res};
      end else if (has_res) begin
        expected_results = {expected_results, r};
      end
    end
    settle();

    plan[0] = 8'h16;
    plan[1] = 8'h00;
    plan[2] = 8'hFF;
    plan[3] = $urandom_range(0, 255);
    plan[4] = 8'h16;
    foreach (plan[p]) begin
      write_service_type(8'(plan[p]));
      // receiver stalls long while words keep coming
      if (p == 1) hold_req = 1'b1;
      record_items = 0;
      while (record_items < ITEMS_PER_PHASE) begin
        run_record();
        if (p == 3 && !paused && record_items > ITEMS_PER_PHASE / 2) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
